>>> rtl/sensor_level_bar_display_defines.svh
// ----------------------------------------------------------------------------
// sensor level bar display assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SENSOR_LEVEL_BAR_DISPLAY_DEFINES_SVH
`define SENSOR_LEVEL_BAR_DISPLAY_DEFINES_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define SLBD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// implication checked on every rising clock edge outside reset
`define SLBD_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);
`else
`define SLBD_ASSERT(lbl, prop, msg)
`define SLBD_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

>>> rtl/slbd_pkg.sv
// ----------------------------------------------------------------------------
// slbd_pkg
// types and fixed constants of the sensor level bar display
// ----------------------------------------------------------------------------
`default_nettype none

package slbd_pkg;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_PICK = 9'b000000010,
      ST_LVL0 = 9'b000000100,
      ST_LVL1 = 9'b000001000,
      ST_BAR  = 9'b000010000,
      ST_DIVQ = 9'b000100000,
      ST_DIVR = 9'b001000000,
      ST_LERP = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   // register indexes
   localparam logic [2:0] CSR_TEMP_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_FAN_ENABLE     = 3'd1;
   localparam logic [2:0] CSR_TEMP_LED_COUNT = 3'd2;
   localparam logic [2:0] CSR_FAN_LED_COUNT  = 3'd3;
   localparam logic [2:0] CSR_SINGLE_SAMPLE  = 3'd4;

   localparam logic CHAN_TEMP = 1'b0;
   localparam logic CHAN_FAN  = 1'b1;

   // color component being interpolated
   localparam logic [1:0] COMP_R = 2'd0;
   localparam logic [1:0] COMP_G = 2'd1;
   localparam logic [1:0] COMP_B = 2'd2;

   localparam logic [3:0] MAX_LEDS = 4'd10;

   localparam logic [23:0] COLOR_GREEN  = 24'h00FF00;
   localparam logic [23:0] COLOR_YELLOW = 24'hFFFF00;
   localparam logic [23:0] COLOR_RED    = 24'hFF0000;
   localparam logic [23:0] COLOR_BLUE   = 24'h0066FF;
   localparam logic [23:0] COLOR_ORANGE = 24'hFF7A00;
   localparam logic [23:0] COLOR_FAIL   = 24'h400000;

   // reading limits
   localparam logic [7:0] READING_MAX    = 8'd100;
   localparam logic [7:0] FAN_DOUBLE_MAX = 8'd50;

   // moving average, alpha 90/256, q7.8 level
   localparam logic [7:0]  EMA_ALPHA = 8'd90;
   localparam logic [7:0]  EMA_KEEP  = 8'd166;
   localparam logic [22:0] EMA_ROUND = 23'd128;
   localparam logic [14:0] LEVEL_MAX = 15'd25600;

   // full scale in q7.8 and half a bar step for rounding
   localparam logic [14:0] TEMP_FULL_LVL = 15'd16640;
   localparam logic [14:0] FAN_FULL_LVL  = 15'd25600;
   localparam logic [18:0] TEMP_HALF     = 19'd8320;
   localparam logic [18:0] FAN_HALF      = 19'd12800;

   // color knees in q7.8
   localparam logic [14:0] TEMP_KNEE1 = 15'd6400;
   localparam logic [14:0] TEMP_KNEE2 = 15'd11520;
   localparam logic [14:0] FAN_KNEE1  = 15'd8448;
   localparam logic [14:0] FAN_KNEE2  = 15'd16896;

   // constant divisors and floor(65536 / d)
   localparam logic [6:0]  DIV_TEMP_FULL = 7'd65;
   localparam logic [6:0]  DIV_FAN_FULL  = 7'd100;
   localparam logic [6:0]  DIV_TEMP_SEG1 = 7'd25;
   localparam logic [6:0]  DIV_TEMP_SEG2 = 7'd20;
   localparam logic [6:0]  DIV_FAN_SEG   = 7'd33;
   localparam logic [11:0] RCP_TEMP_FULL = 12'd1008;
   localparam logic [11:0] RCP_FAN_FULL  = 12'd655;
   localparam logic [11:0] RCP_TEMP_SEG1 = 12'd2621;
   localparam logic [11:0] RCP_TEMP_SEG2 = 12'd3276;
   localparam logic [11:0] RCP_FAN_SEG   = 12'd1985;

endpackage

`default_nettype wire

>>> rtl/sensor_level_bar_display.sv
// ----------------------------------------------------------------------------
// sensor_level_bar_display
// turns temperature and fan poll results into led bar updates
// ----------------------------------------------------------------------------
// Each request beat carries one poll result (channel, up to three samples and
// the sample count) and yields exactly one response beat: the lit led count,
// the 0xRRGGBB bar color, a fail flag and the accepted reading. Samples are
// reduced to one reading (first sample, floored mean of two, median of three),
// checked and scaled, then folded into the channel's q7.8 level by a moving
// average; bar length and color come from that level. Every multiply runs
// through one 16x16 multiplier under a small sequencer, one product per cycle,
// and constant divisions use reciprocal multiply plus one correction step. An
// item passes PICK, LVL0, LVL1, BAR, DIVQ, DIVR (bar), DIVQ, DIVR (color) and
// a LERP per component to EMIT; past the last knee it skips from DIVR to EMIT,
// a failed read or disabled channel from PICK; req_stall is high the whole time.
// The response sits in an output register, so the next request is taken the
// cycle after an item finishes even while that response is still stalled.
// Registers are written through csr_write/csr_index/csr_wdata and should only
// change while no item is in flight.
`default_nettype none

`include "sensor_level_bar_display_defines.svh"

module sensor_level_bar_display
   import slbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_channel,
   input  wire logic [7:0]  req_sample_a,
   input  wire logic [7:0]  req_sample_b,
   input  wire logic [7:0]  req_sample_c,
   input  wire logic [1:0]  req_sample_count,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_bar_channel,
   output logic [3:0]       rsp_lit_count,
   output logic [23:0]      rsp_bar_color,
   output logic             rsp_fail,
   output logic [6:0]       rsp_reading,
   // register write port
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [3:0]  csr_wdata
);

   // ---------------------------------------------------------------- registers
   state_type   state_ff, state_in;

   // configuration
   logic        temp_enable_ff, temp_enable_in;
   logic        fan_enable_ff, fan_enable_in;
   logic [3:0]  temp_led_count_ff, temp_led_count_in;
   logic [3:0]  fan_led_count_ff, fan_led_count_in;
   logic        single_sample_ff, single_sample_in;

   // per channel q7.8 levels
   logic [14:0] temp_level_ff, temp_level_in;
   logic [14:0] fan_level_ff, fan_level_in;

   // captured request beat
   logic        ch_ff, ch_in;
   logic [7:0]  a_ff, a_in;
   logic [7:0]  b_ff, b_in;
   logic [7:0]  c_ff, c_in;
   logic [1:0]  cnt_ff, cnt_in;

   // working values
   logic [6:0]  reading_ff, reading_in;
   logic [22:0] acc_ff, acc_in;
   logic [14:0] lvl_ff, lvl_in;
   logic [3:0]  lit_ff, lit_in;
   logic [23:0] color_ff, color_in;
   logic        fail_ff, fail_in;

   // constant divider operands
   logic [13:0] div_x_ff, div_x_in;
   logic [6:0]  div_d_ff, div_d_in;
   logic [11:0] div_rcp_ff, div_rcp_in;
   logic [8:0]  div_q_ff, div_q_in;
   logic        div_bar_ff, div_bar_in;

   // color interpolation
   logic [23:0] col_a_ff, col_a_in;
   logic [23:0] col_b_ff, col_b_in;
   logic [8:0]  t_ff, t_in;
   logic [1:0]  comp_ff, comp_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ch_ff, rsp_ch_in;
   logic [3:0]  rsp_lit_ff, rsp_lit_in;
   logic [23:0] rsp_color_ff, rsp_color_in;
   logic        rsp_fail_ff, rsp_fail_in;
   logic [6:0]  rsp_reading_ff, rsp_reading_in;

   // ---------------------------------------------------------- shared multiplier
   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [31:0] prod;

   assign prod = mul_a * mul_b;

   // -------------------------------------------------------- channel selection
   logic        chan_en;
   logic [3:0]  n_raw;
   logic [3:0]  n_sat;
   logic [14:0] lvl_old;

   assign chan_en = (ch_ff == CHAN_FAN) ? fan_enable_ff : temp_enable_ff;
   assign n_raw   = (ch_ff == CHAN_FAN) ? fan_led_count_ff : temp_led_count_ff;
   assign n_sat   = (n_raw > MAX_LEDS) ? MAX_LEDS : n_raw;
   assign lvl_old = (ch_ff == CHAN_FAN) ? fan_level_ff : temp_level_ff;

   // ----------------------------------------------------------- sample forming
   logic [8:0]  pair_sum;
   logic [7:0]  lo_ab;
   logic [7:0]  hi_ab;
   logic [7:0]  median;
   logic [7:0]  picked;
   logic [7:0]  doubled;
   logic [7:0]  scaled;
   logic        bad;

   assign pair_sum = {1'b0, a_ff} + {1'b0, b_ff};
   assign lo_ab    = (a_ff < b_ff) ? a_ff : b_ff;
   assign hi_ab    = (a_ff > b_ff) ? a_ff : b_ff;
   assign median   = (c_ff < lo_ab) ? lo_ab : ((c_ff > hi_ab) ? hi_ab : c_ff);

   always_comb begin
      // single sample mode and a lone sample both use the first byte
      priority if (single_sample_ff || cnt_ff == 2'd1) begin
         picked = a_ff;
      end else if (cnt_ff == 2'd2) begin
         picked = pair_sum[8:1];
      end else begin
         picked = median;
      end
   end

   // fan readings up to half scale are doubled, then capped at full scale
   assign doubled = (picked <= FAN_DOUBLE_MAX) ? {picked[6:0], 1'b0} : picked;
   assign scaled  = (ch_ff == CHAN_FAN) ?
                    ((doubled > READING_MAX) ? READING_MAX : doubled) : picked;
   // no samples, or an implausible temperature
   assign bad     = (cnt_ff == 2'd0) || (ch_ff == CHAN_TEMP && picked > READING_MAX);

   // -------------------------------------------------------- datapath helpers
   logic [22:0] lvl_sum;
   logic [14:0] bar_lc;
   logic [18:0] bar_x;
   logic [13:0] div_rem;
   logic [8:0]  div_q_fix;
   logic [14:0] col_lc;
   logic [14:0] col_off;
   logic [7:0]  comp_a;
   logic [7:0]  comp_b;
   logic        comp_up;
   logic [7:0]  comp_mag;
   logic [16:0] comp_base;
   logic [16:0] comp_sum;
   logic [7:0]  comp_val;

   assign lvl_sum = acc_ff + prod[22:0];

   // level clamped to the bar's full scale
   always_comb begin
      if (ch_ff == CHAN_FAN) begin
         bar_lc = (lvl_ff > FAN_FULL_LVL) ? FAN_FULL_LVL : lvl_ff;
      end else begin
         bar_lc = (lvl_ff > TEMP_FULL_LVL) ? TEMP_FULL_LVL : lvl_ff;
      end
   end

   // level * n plus half a step; the low byte drops before the divide
   assign bar_x = prod[18:0] + ((ch_ff == CHAN_FAN) ? FAN_HALF : TEMP_HALF);

   // reciprocal quotient is low by at most one, one correction fixes it
   assign div_rem   = div_x_ff - prod[13:0];
   assign div_q_fix = (div_rem >= {7'd0, div_d_ff}) ? (div_q_ff + 9'd1) : div_q_ff;

   assign col_lc  = bar_lc;
   assign col_off = col_lc - ((ch_ff == CHAN_FAN) ?
                    ((col_lc <= FAN_KNEE1) ? 15'd0 : FAN_KNEE1) :
                    ((col_lc <= TEMP_KNEE1) ? 15'd0 : TEMP_KNEE1));

   always_comb begin
      unique case (comp_ff)
         COMP_R: begin
            comp_a = col_a_ff[23:16];
            comp_b = col_b_ff[23:16];
         end
         COMP_G: begin
            comp_a = col_a_ff[15:8];
            comp_b = col_b_ff[15:8];
         end
         default: begin
            comp_a = col_a_ff[7:0];
            comp_b = col_b_ff[7:0];
         end
      endcase
   end

   // a + (b - a) * t / 256, with the difference kept as sign and magnitude
   assign comp_up   = (comp_b >= comp_a);
   assign comp_mag  = comp_up ? (comp_b - comp_a) : (comp_a - comp_b);
   assign comp_base = {1'b0, comp_a, 8'd0};
   assign comp_sum  = comp_up ? (comp_base + prod[16:0]) : (comp_base - prod[16:0]);
   assign comp_val  = comp_sum[15:8];

   // --------------------------------------------------------------- sequencer
   always_comb begin
      state_in          = state_ff;
      temp_enable_in    = temp_enable_ff;
      fan_enable_in     = fan_enable_ff;
      temp_led_count_in = temp_led_count_ff;
      fan_led_count_in  = fan_led_count_ff;
      single_sample_in  = single_sample_ff;
      temp_level_in     = temp_level_ff;
      fan_level_in      = fan_level_ff;
      ch_in             = ch_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      c_in              = c_ff;
      cnt_in            = cnt_ff;
      reading_in        = reading_ff;
      acc_in            = acc_ff;
      lvl_in            = lvl_ff;
      lit_in            = lit_ff;
      color_in          = color_ff;
      fail_in           = fail_ff;
      div_x_in          = div_x_ff;
      div_d_in          = div_d_ff;
      div_rcp_in        = div_rcp_ff;
      div_q_in          = div_q_ff;
      div_bar_in        = div_bar_ff;
      col_a_in          = col_a_ff;
      col_b_in          = col_b_ff;
      t_in              = t_ff;
      comp_in           = comp_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_ch_in         = rsp_ch_ff;
      rsp_lit_in        = rsp_lit_ff;
      rsp_color_in      = rsp_color_ff;
      rsp_fail_in       = rsp_fail_ff;
      rsp_reading_in    = rsp_reading_ff;
      mul_a             = '0;
      mul_b             = '0;

      // register writes
      if (csr_write) begin
         unique case (csr_index)
            CSR_TEMP_ENABLE:    temp_enable_in    = csr_wdata[0];
            CSR_FAN_ENABLE:     fan_enable_in     = csr_wdata[0];
            CSR_TEMP_LED_COUNT: temp_led_count_in = csr_wdata;
            CSR_FAN_LED_COUNT:  fan_led_count_in  = csr_wdata;
            CSR_SINGLE_SAMPLE:  single_sample_in  = csr_wdata[0];
            default: ;
         endcase
      end

      // response beat taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in    = req_channel;
               a_in     = req_sample_a;
               b_in     = req_sample_b;
               c_in     = req_sample_c;
               cnt_in   = req_sample_count;
               state_in = ST_PICK;
            end
         end

         ST_PICK: begin
            if (!chan_en) begin
               // blank bar, level untouched
               lit_in     = 4'd0;
               color_in   = 24'd0;
               fail_in    = 1'b0;
               reading_in = 7'd0;
               state_in   = ST_EMIT;
            end else if (bad) begin
               // dim red first pixel, level untouched
               lit_in     = (n_sat != 4'd0) ? 4'd1 : 4'd0;
               color_in   = COLOR_FAIL;
               fail_in    = 1'b1;
               reading_in = 7'd0;
               state_in   = ST_EMIT;
            end else begin
               fail_in    = 1'b0;
               reading_in = scaled[6:0];
               state_in   = ST_LVL0;
            end
         end

         ST_LVL0: begin
            // alpha * reading in q7.8 plus rounding
            mul_a    = 16'(EMA_ALPHA);
            mul_b    = 16'(reading_ff);
            acc_in   = {prod[14:0], 8'd0} + EMA_ROUND;
            state_in = ST_LVL1;
         end

         ST_LVL1: begin
            // add (256 - alpha) * old level, drop the fraction byte
            mul_a  = 16'(EMA_KEEP);
            mul_b  = 16'(lvl_old);
            lvl_in = lvl_sum[22:8];
            if (ch_ff == CHAN_FAN) begin
               fan_level_in = lvl_sum[22:8];
            end else begin
               temp_level_in = lvl_sum[22:8];
            end
            state_in = ST_BAR;
         end

         ST_BAR: begin
            // bar length = floor((L*n + 128F) / 256 / F)
            mul_a      = 16'(bar_lc);
            mul_b      = 16'(n_sat);
            div_x_in   = 14'(bar_x[18:8]);
            div_d_in   = (ch_ff == CHAN_FAN) ? DIV_FAN_FULL : DIV_TEMP_FULL;
            div_rcp_in = (ch_ff == CHAN_FAN) ? RCP_FAN_FULL : RCP_TEMP_FULL;
            div_bar_in = 1'b1;
            state_in   = ST_DIVQ;
         end

         ST_DIVQ: begin
            mul_a    = 16'(div_x_ff);
            mul_b    = 16'(div_rcp_ff);
            div_q_in = prod[24:16];
            state_in = ST_DIVR;
         end

         ST_DIVR: begin
            mul_a = 16'(div_q_ff);
            mul_b = 16'(div_d_ff);
            if (div_bar_ff) begin
               lit_in     = (div_q_fix > {5'd0, n_sat}) ? n_sat : div_q_fix[3:0];
               div_bar_in = 1'b0;
               div_x_in   = col_off[13:0];
               state_in   = ST_DIVQ;
               // pick the color segment from the clamped level
               if (ch_ff == CHAN_FAN) begin
                  div_d_in   = DIV_FAN_SEG;
                  div_rcp_in = RCP_FAN_SEG;
                  priority if (col_lc <= FAN_KNEE1) begin
                     col_a_in = COLOR_BLUE;
                     col_b_in = COLOR_YELLOW;
                  end else if (col_lc <= FAN_KNEE2) begin
                     col_a_in = COLOR_YELLOW;
                     col_b_in = COLOR_ORANGE;
                  end else begin
                     color_in = COLOR_ORANGE;
                     state_in = ST_EMIT;
                  end
               end else begin
                  priority if (col_lc <= TEMP_KNEE1) begin
                     div_d_in   = DIV_TEMP_SEG1;
                     div_rcp_in = RCP_TEMP_SEG1;
                     col_a_in   = COLOR_GREEN;
                     col_b_in   = COLOR_YELLOW;
                  end else if (col_lc <= TEMP_KNEE2) begin
                     div_d_in   = DIV_TEMP_SEG2;
                     div_rcp_in = RCP_TEMP_SEG2;
                     col_a_in   = COLOR_YELLOW;
                     col_b_in   = COLOR_RED;
                  end else begin
                     color_in = COLOR_RED;
                     state_in = ST_EMIT;
                  end
               end
            end else begin
               // color fraction in 1/256 units
               t_in     = div_q_fix;
               comp_in  = COMP_R;
               state_in = ST_LERP;
            end
         end

         ST_LERP: begin
            mul_a = 16'(comp_mag);
            mul_b = 16'(t_ff);
            unique case (comp_ff)
               COMP_R:  color_in[23:16] = comp_val;
               COMP_G:  color_in[15:8]  = comp_val;
               default: color_in[7:0]   = comp_val;
            endcase
            if (comp_ff == COMP_B) begin
               state_in = ST_EMIT;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end

         ST_EMIT: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_ch_in      = ch_ff;
               rsp_lit_in     = lit_ff;
               rsp_color_in   = color_ff;
               rsp_fail_in    = fail_ff;
               rsp_reading_in = reading_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         temp_enable_ff    <= 1'b1;
         fan_enable_ff     <= 1'b1;
         temp_led_count_ff <= 4'd5;
         fan_led_count_ff  <= 4'd5;
         single_sample_ff  <= 1'b0;
         temp_level_ff     <= 15'd0;
         fan_level_ff      <= 15'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         temp_enable_ff    <= temp_enable_in;
         fan_enable_ff     <= fan_enable_in;
         temp_led_count_ff <= temp_led_count_in;
         fan_led_count_ff  <= fan_led_count_in;
         single_sample_ff  <= single_sample_in;
         temp_level_ff     <= temp_level_in;
         fan_level_ff      <= fan_level_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      ch_ff          <= ch_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      c_ff           <= c_in;
      cnt_ff         <= cnt_in;
      reading_ff     <= reading_in;
      acc_ff         <= acc_in;
      lvl_ff         <= lvl_in;
      lit_ff         <= lit_in;
      color_ff       <= color_in;
      fail_ff        <= fail_in;
      div_x_ff       <= div_x_in;
      div_d_ff       <= div_d_in;
      div_rcp_ff     <= div_rcp_in;
      div_q_ff       <= div_q_in;
      div_bar_ff     <= div_bar_in;
      col_a_ff       <= col_a_in;
      col_b_ff       <= col_b_in;
      t_ff           <= t_in;
      comp_ff        <= comp_in;
      rsp_ch_ff      <= rsp_ch_in;
      rsp_lit_ff     <= rsp_lit_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_fail_ff    <= rsp_fail_in;
      rsp_reading_ff <= rsp_reading_in;
   end

   // ------------------------------------------------------------------ outputs
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bar_channel = rsp_ch_ff;
   assign rsp_lit_count   = rsp_lit_ff;
   assign rsp_bar_color   = rsp_color_ff;
   assign rsp_fail        = rsp_fail_ff;
   assign rsp_reading     = rsp_reading_ff;

   // --------------------------------------------------------------- assertions
   `SLBD_ASSERT(a_accept_starts_item, req_valid && !req_stall |=> state_ff == ST_PICK, "no item")
   `SLBD_ASSERT_IMPL(a_div_fix, state_ff == ST_DIVR, div_rem[13:1] < 13'(div_d_ff), "bad quotient")
   `SLBD_ASSERT_IMPL(a_fail_beat, rsp_valid && rsp_fail, rsp_bar_color == COLOR_FAIL, "bad beat")
   `SLBD_ASSERT(a_level, temp_level_ff <= LEVEL_MAX && fan_level_ff <= LEVEL_MAX, "level high")

endmodule

`default_nettype wire

>>> dv/bar_update_checker.sv
// ----------------------------------------------------------------------------
// bar_update_checker
// tracks register writes and request beats, predicts each bar update from a
// private copy of both channel levels, and compares every response beat
// field by field against the oldest prediction
// ----------------------------------------------------------------------------
module bar_update_checker
   import slbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_channel,
   input  logic [7:0]        req_sample_a,
   input  logic [7:0]        req_sample_b,
   input  logic [7:0]        req_sample_c,
   input  logic [1:0]        req_sample_count,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_bar_channel,
   input  logic [3:0]        rsp_lit_count,
   input  logic [23:0]       rsp_bar_color,
   input  logic              rsp_fail,
   input  logic [6:0]        rsp_reading,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [3:0]        csr_wdata,
   output int unsigned       error_count,
   output int unsigned       pending_results,
   output int unsigned       updates_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        bar_channel;
      logic [3:0]  lit_count;
      logic [23:0] bar_color;
      logic        fail;
      logic [6:0]  reading;
   } bar_update_type;

   bar_update_type expected_updates[$];

   // register mirror
   logic       temp_on, fan_on, single_mode;
   logic [3:0] temp_leds, fan_leds;

   // q7.8 channel levels
   logic [14:0] temp_level, fan_level;

   function automatic logic [23:0] lerp_color(input logic [23:0] from_rgb,
                                              input logic [23:0] to_rgb,
                                              input int unsigned frac);
      logic [23:0] rgb;
      int          ca, cb, k;
      rgb = '0;
      if (frac > 256) frac = 256;
      for (k = 0; k < 3; k++) begin
         ca = from_rgb[8*k +: 8];
         cb = to_rgb[8*k +: 8];
         rgb[8*k +: 8] = 8'((ca * 256 + (cb - ca) * int'(frac)) >>> 8);
      end
      return rgb;
   endfunction

   // computes the display update for one poll; a good reading on an enabled channel advances that channel's level
   function automatic bar_update_type next_bar_update(input logic ch, input logic [7:0] a,
                                                      input logic [7:0] b, input logic [7:0] c,
                                                      input logic [1:0] cnt);
      bar_update_type upd;
      logic [3:0]  leds;
      logic        bad;
      logic [23:0] rgb;
      int unsigned v, lo, hi, lv, full, lit;
      upd = '0;
      upd.bar_channel = ch;
      leds = (ch == CHAN_FAN) ? fan_leds : temp_leds;
      if (leds > MAX_LEDS) leds = MAX_LEDS;
      if ((ch == CHAN_FAN) ? !fan_on : !temp_on) return upd;

      v   = 0;
      bad = (cnt == 2'd0);
      if (!bad) begin
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         if (single_mode || cnt == 2'd1) v = a;
         else if (cnt == 2'd2) v = (32'(a) + 32'(b)) >> 1;
         else v = (c < lo) ? lo : ((c > hi) ? hi : c);
         if (ch == CHAN_TEMP) begin
            bad = (v > READING_MAX);
         end else begin
            if (v <= FAN_DOUBLE_MAX) v = v * 2;
            if (v > READING_MAX) v = READING_MAX;
         end
      end

      if (bad) begin
         upd.lit_count = (leds != 4'd0) ? 4'd1 : 4'd0;
         upd.bar_color = COLOR_FAIL;
         upd.fail      = 1'b1;
         return upd;
      end

      // moving average, alpha 90/256, rounded half up
      lv = (ch == CHAN_FAN) ? fan_level : temp_level;
      lv = ((90 * (v << 8) + 166 * lv + 128) >> 8) & 32'h7FFF;
      if (ch == CHAN_FAN) fan_level = 15'(lv);
      else temp_level = 15'(lv);

      full = (ch == CHAN_FAN) ? 100 : 65;
      if (lv > full * 256) lv = full * 256;
      lit = (2 * lv * leds + 256 * full) / (512 * full);
      upd.lit_count = 4'((lit > leds) ? leds : lit);

      if (ch == CHAN_TEMP) begin
         if (lv <= 25 * 256) rgb = lerp_color(COLOR_GREEN, COLOR_YELLOW, lv / 25);
         else if (lv <= 45 * 256) rgb = lerp_color(COLOR_YELLOW, COLOR_RED, (lv - 25 * 256) / 20);
         else rgb = COLOR_RED;
      end else begin
         if (lv <= 33 * 256) rgb = lerp_color(COLOR_BLUE, COLOR_YELLOW, lv / 33);
         else if (lv <= 66 * 256)
            rgb = lerp_color(COLOR_YELLOW, COLOR_ORANGE, (lv - 33 * 256) / 33);
         else rgb = COLOR_ORANGE;
      end
      upd.bar_color = rgb;
      upd.reading   = 7'(v);
      return upd;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      bar_update_type want;
      if (reset) begin
         expected_updates.delete();
         temp_on         = 1'b1;
         fan_on          = 1'b1;
         temp_leds       = 4'd5;
         fan_leds        = 4'd5;
         single_mode     = 1'b0;
         temp_level      = '0;
         fan_level       = '0;
         error_count     = 0;
         updates_checked = 0;
      end else begin
         // compare first so a beat leaving and one entering on the same edge stay ordered
         if (rsp_valid && !rsp_stall) begin
            updates_checked++;
            if (expected_updates.size() == 0) begin
               $error("bar update beat with nothing expected, channel %0d", rsp_bar_channel);
               error_count++;
            end else begin
               want = expected_updates.pop_front();
               check_field("bar_channel", want.bar_channel, rsp_bar_channel);
               check_field("lit_count", want.lit_count, rsp_lit_count);
               check_field("bar_color", want.bar_color, rsp_bar_color);
               check_field("fail", want.fail, rsp_fail);
               check_field("reading", want.reading, rsp_reading);
            end
         end
         if (req_valid && !req_stall)
            expected_updates.push_back(next_bar_update(req_channel, req_sample_a,
                                                       req_sample_b, req_sample_c,
                                                       req_sample_count));
         if (csr_write) begin
            case (csr_index)
               CSR_TEMP_ENABLE:    temp_on     = csr_wdata[0];
               CSR_FAN_ENABLE:     fan_on      = csr_wdata[0];
               CSR_TEMP_LED_COUNT: temp_leds   = csr_wdata;
               CSR_FAN_LED_COUNT:  fan_leds    = csr_wdata;
               CSR_SINGLE_SAMPLE:  single_mode = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending_results = expected_updates.size();
   end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives poll beats and register settings into the sensor level bar display,
// with random sender gaps and receiver stalls, and reports the verdict that
// the bar update checker beside the block arrives at
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import slbd_pkg::*;

   // first register index past the defined ones; writes there must be dropped
   localparam logic [2:0] CSR_FIRST_UNUSED = CSR_SINGLE_SAMPLE + 3'd1;

   localparam int NUM_PHASES      = 10;
   localparam int POLLS_PER_PHASE = 200;
   localparam int HOLD_PHASE      = 6;      // receiver holds off at the start of this phase
   localparam int HOLD_CYCLES     = 400;
   localparam int RESULT_LATENCY  = 12;     // longest unstalled accept-to-response time
   localparam int CYCLE_LIMIT     = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_channel      = 1'b0;
   logic [7:0]  req_sample_a     = '0;
   logic [7:0]  req_sample_b     = '0;
   logic [7:0]  req_sample_c     = '0;
   logic [1:0]  req_sample_count = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_bar_channel;
   logic [3:0]  rsp_lit_count;
   logic [23:0] rsp_bar_color;
   logic        rsp_fail;
   logic [6:0]  rsp_reading;

   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [3:0]  csr_wdata = '0;

   int unsigned error_count;
   int unsigned pending_results;
   int unsigned updates_checked;

   // idling controls, shared between the stimulus and the receiver
   logic        sender_idles = 1'b0;
   logic        rsp_idles    = 1'b0;
   logic        hold_rsp     = 1'b0;

   int unsigned polls_sent     = 0;
   int unsigned settings_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sensor_level_bar_display dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_sample_c     (req_sample_c),
      .req_sample_count (req_sample_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bar_channel  (rsp_bar_channel),
      .rsp_lit_count    (rsp_lit_count),
      .rsp_bar_color    (rsp_bar_color),
      .rsp_fail         (rsp_fail),
      .rsp_reading      (rsp_reading),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   bar_update_checker bar_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_sample_c     (req_sample_c),
      .req_sample_count (req_sample_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bar_channel  (rsp_bar_channel),
      .rsp_lit_count    (rsp_lit_count),
      .rsp_bar_color    (rsp_bar_color),
      .rsp_fail         (rsp_fail),
      .rsp_reading      (rsp_reading),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_results  (pending_results),
      .updates_checked  (updates_checked)
   );

   // one poll beat; inputs move on the falling edge, acceptance is judged on the
   // rising edge. valid stays high on return so back-to-back beats need no drop
   task automatic send_poll(input logic ch, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [1:0] cnt);
      int unsigned gap;
      gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_channel      <= ch;
      req_sample_a     <= a;
      req_sample_b     <= b;
      req_sample_c     <= c;
      req_sample_count <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      polls_sent++;
   endtask

   // sender goes quiet and waits until every predicted update has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   // single-cycle register write, only ever issued while the block is idle
   task automatic write_reg(input logic [2:0] idx, input logic [3:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (rsp_idles && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // a hung handshake ends the run here
   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $error("watchdog: run still busy after %0d cycles", CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int         p, i, k, v;
      int         target[2];
      logic [7:0] s[3];
      logic       ch, temp_en, fan_en, one_sample;
      logic [1:0] cnt;
      logic [3:0] temp_n, fan_n;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // ---- directed, reset settings: enabled, 5 leds each, median mode ----
      settings_count++;
      send_poll(CHAN_TEMP, 8'd0, 8'd0, 8'd0, 2'd0);         // read failed
      send_poll(CHAN_FAN, 8'd0, 8'd0, 8'd0, 2'd0);          // read failed
      send_poll(CHAN_TEMP, 8'd100, 8'd255, 8'd255, 2'd1);   // top plausible temp
      send_poll(CHAN_TEMP, 8'd101, 8'd0, 8'd0, 2'd1);       // just implausible
      send_poll(CHAN_TEMP, 8'd0, 8'd0, 8'd0, 2'd1);
      send_poll(CHAN_TEMP, 8'd255, 8'd0, 8'd0, 2'd2);       // mean 127, implausible
      send_poll(CHAN_TEMP, 8'd101, 8'd100, 8'd0, 2'd2);     // mean floors to 100
      send_poll(CHAN_TEMP, 8'd10, 8'd90, 8'd5, 2'd3);       // third below both
      send_poll(CHAN_TEMP, 8'd90, 8'd10, 8'd200, 2'd3);     // third above both
      send_poll(CHAN_TEMP, 8'd40, 8'd60, 8'd50, 2'd3);      // third in between
      send_poll(CHAN_FAN, 8'd50, 8'd0, 8'd0, 2'd1);         // doubled to full scale
      send_poll(CHAN_FAN, 8'd51, 8'd0, 8'd0, 2'd1);         // first value not doubled
      send_poll(CHAN_FAN, 8'd255, 8'd0, 8'd0, 2'd1);        // clamped to 100
      send_poll(CHAN_FAN, 8'd0, 8'd1, 8'd0, 2'd2);
      send_poll(CHAN_FAN, 8'd255, 8'd255, 8'd0, 2'd3);
      drain_results();

      // single-sample mode ignores the median and the mean
      write_reg(CSR_SINGLE_SAMPLE, 4'd1);
      settings_count++;
      send_poll(CHAN_TEMP, 8'd20, 8'd200, 8'd200, 2'd3);
      send_poll(CHAN_FAN, 8'd30, 8'd250, 8'd0, 2'd2);
      send_poll(CHAN_TEMP, 8'd20, 8'd20, 8'd20, 2'd0);      // still a failed read
      drain_results();

      // empty temperature bar, oversized fan bar, and a write to no register
      write_reg(CSR_TEMP_LED_COUNT, 4'd0);
      write_reg(CSR_FAN_LED_COUNT, 4'd15);
      write_reg(CSR_FIRST_UNUSED, 4'd15);
      settings_count++;
      send_poll(CHAN_TEMP, 8'd0, 8'd0, 8'd0, 2'd0);
      send_poll(CHAN_TEMP, 8'd100, 8'd0, 8'd0, 2'd1);
      send_poll(CHAN_FAN, 8'd100, 8'd0, 8'd0, 2'd1);
      drain_results();

      // both bars blanked
      write_reg(CSR_TEMP_ENABLE, 4'd0);
      write_reg(CSR_FAN_ENABLE, 4'd0);
      settings_count++;
      send_poll(CHAN_TEMP, 8'd50, 8'd0, 8'd0, 2'd1);
      send_poll(CHAN_FAN, 8'd0, 8'd0, 8'd0, 2'd0);
      drain_results();

      // ---- random phases ----
      // polls follow a slowly moving target per channel so the levels sweep
      // through every color segment; spikes, failed reads and wild samples mix in
      target[0] = $urandom_range(0, 110);
      target[1] = $urandom_range(0, 120);
      for (p = 0; p < NUM_PHASES; p++) begin
         temp_en    = (p != 2);
         fan_en     = (p != 5);
         one_sample = (p == 4 || p == 8);
         case (p)
            0: begin
               temp_n = MAX_LEDS;
               fan_n  = MAX_LEDS;
            end
            1: begin
               temp_n = 4'd0;
               fan_n  = 4'd0;
            end
            3: begin
               temp_n = 4'd15;
               fan_n  = 4'd11;
            end
            default: begin
               temp_n = 4'($urandom_range(0, 15));
               fan_n  = 4'($urandom_range(0, 15));
            end
         endcase
         // upper data bits are junk for the one-bit registers
         write_reg(CSR_TEMP_ENABLE, {3'($urandom_range(0, 7)), temp_en});
         write_reg(CSR_FAN_ENABLE, {3'($urandom_range(0, 7)), fan_en});
         write_reg(CSR_TEMP_LED_COUNT, temp_n);
         write_reg(CSR_FAN_LED_COUNT, fan_n);
         write_reg(CSR_SINGLE_SAMPLE, {3'($urandom_range(0, 7)), one_sample});
         write_reg(CSR_FIRST_UNUSED + 3'($urandom_range(0, 2)), 4'($urandom_range(0, 15)));
         settings_count++;

         // last phase runs flat out on both sides
         sender_idles = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_idles    = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         if (p == HOLD_PHASE) begin
            // receiver backs off while polls keep coming, so the block fills and stalls
            sender_idles = 1'b0;
            hold_rsp     = 1'b1;
         end

         for (i = 0; i < POLLS_PER_PHASE; i++) begin
            ch = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 15) == 0) target[ch] = $urandom_range(0, 120);
            for (k = 0; k < 3; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  s[k] = 8'($urandom_range(0, 255));
               end else begin
                  v = target[ch] + int'($urandom_range(0, 8)) - 4;
                  s[k] = 8'((v < 0) ? 0 : v);
               end
            end
            cnt = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            send_poll(ch, s[0], s[1], s[2], cnt);
         end
         drain_results();
      end

      // let any stray beat surface before judging
      repeat (4 * RESULT_LATENCY) @(negedge clock);

      $display("run covered %0d polls under %0d register settings, %0d bar updates checked",
               polls_sent, settings_count, updates_checked);
      if (error_count == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/slbd_pkg.sv
rtl/sensor_level_bar_display.sv
dv/bar_update_checker.sv
dv/tb_top.sv
